// ===== rtl/lkd_pkg.sv =====
// Shared types, constants and register codes for the ladder keypad debouncer.
// Used by every module of the block; it depends on nothing else.

package lkd_pkg;

    // Block dimensions, fixed by the key set and the field widths
    localparam int NUM_KEYS      = 5;
    localparam int SAMPLE_BITS   = 10;
    localparam int CNT_BITS      = 3;
    localparam int FLAG_BITS     = 5;
    localparam int KEY_IDX_BITS  = 3;
    localparam int REQ_BITS      = 2;
    localparam int CFG_ADDR_BITS = 3;
    localparam int CFG_DATA_BITS = SAMPLE_BITS;

    // Stream payload widths: fields packed from bit 0, padded to whole bytes
    localparam int S_FIELD_BITS  = SAMPLE_BITS + KEY_IDX_BITS + FLAG_BITS;
    localparam int S_TDATA_BITS  = ((S_FIELD_BITS + 7) / 8) * 8;
    localparam int M_FIELD_BITS  = NUM_KEYS * FLAG_BITS;
    localparam int M_TDATA_BITS  = ((M_FIELD_BITS + 7) / 8) * 8;

    typedef logic [SAMPLE_BITS-1:0]  sample_t;
    typedef logic [CNT_BITS-1:0]     cnt_t;
    typedef logic [FLAG_BITS-1:0]    flags_t;
    typedef logic [KEY_IDX_BITS-1:0] key_idx_t;

    // Key positions on the ladder
    localparam int KEY_RIGHT  = 0;
    localparam int KEY_UP     = 1;
    localparam int KEY_DOWN   = 2;
    localparam int KEY_LEFT   = 3;
    localparam int KEY_SELECT = 4;

    // Flag bit positions
    localparam int FL_PRESSED  = 0;
    localparam int FL_RELEASED = 1;
    localparam int FL_PRESS_EV = 2;
    localparam int FL_REL_EV   = 3;
    localparam int FL_LOCKED   = 4;

    localparam flags_t FLAGS_RESET = flags_t'(1 << FL_RELEASED);

    // Request kinds carried in tuser
    typedef enum logic [REQ_BITS-1:0] {
        REQ_TICK  = 2'd0,
        REQ_CLEAR = 2'd1,
        REQ_SET   = 2'd2
    } req_type_t;

    // Configuration register indexes
    typedef enum logic [CFG_ADDR_BITS-1:0] {
        CFG_RIGHT_UPPER       = 3'd0,
        CFG_UP_LOWER          = 3'd1,
        CFG_UP_DOWN_SPLIT     = 3'd2,
        CFG_DOWN_LEFT_SPLIT   = 3'd3,
        CFG_LEFT_SELECT_SPLIT = 3'd4,
        CFG_SELECT_UPPER      = 3'd5,
        CFG_DEBOUNCE_LIMIT    = 3'd6
    } cfg_addr_t;

    // Register reset values
    localparam sample_t RST_RIGHT_UPPER       = sample_t'(25);
    localparam sample_t RST_UP_LOWER          = sample_t'(115);
    localparam sample_t RST_UP_DOWN_SPLIT     = sample_t'(180);
    localparam sample_t RST_DOWN_LEFT_SPLIT   = sample_t'(500);
    localparam sample_t RST_LEFT_SELECT_SPLIT = sample_t'(700);
    localparam sample_t RST_SELECT_UPPER      = sample_t'(1000);
    localparam cnt_t    RST_DEBOUNCE_LIMIT    = cnt_t'(5);

    // Band bounds as held in the configuration registers
    typedef struct packed {
        sample_t right_upper;
        sample_t up_lower;
        sample_t up_down_split;
        sample_t down_left_split;
        sample_t left_select_split;
        sample_t select_upper;
    } bounds_t;

    // Decoded operation handed to every key cell
    typedef struct packed {
        logic   tick;
        logic   clear;
        logic   set;
        flags_t mask;
    } key_op_t;

endpackage

// ===== rtl/lkd_band_sorter.sv =====
// Sorts one ladder sample into the key bands with strict compares.
// Depends on lkd_pkg for the sample and bounds types.

module lkd_band_sorter (
    input  lkd_pkg::sample_t                sample,
    input  lkd_pkg::bounds_t                bounds,
    output logic [lkd_pkg::NUM_KEYS-1:0]    in_band
);
    import lkd_pkg::*;

    // Each key tests its own band, so overlapping bounds may hit several keys
    always_comb begin
        in_band             = '0;
        in_band[KEY_RIGHT]  = sample < bounds.right_upper;
        in_band[KEY_UP]     = (sample > bounds.up_lower)
                              && (sample < bounds.up_down_split);
        in_band[KEY_DOWN]   = (sample > bounds.up_down_split)
                              && (sample < bounds.down_left_split);
        in_band[KEY_LEFT]   = (sample > bounds.down_left_split)
                              && (sample < bounds.left_select_split);
        in_band[KEY_SELECT] = (sample > bounds.left_select_split)
                              && (sample < bounds.select_upper);
    end

endmodule

// ===== rtl/lkd_key_cell.sv =====
// One key: integrating debounce counter and flag register.
// Depends on lkd_pkg for the operation struct and flag bit positions.

module lkd_key_cell (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             advance,
    input  lkd_pkg::key_op_t op,
    input  logic             key_sel,
    input  logic             in_band,
    input  lkd_pkg::cnt_t    limit,
    output lkd_pkg::flags_t  flags_next
);
    import lkd_pkg::*;

    cnt_t   counter_reg;
    cnt_t   counter_next;
    flags_t flags_reg;

    // Next counter and flags for the operation held in the item register.
    // An unknown request or another key's set or clear leaves both unchanged.
    always_comb begin
        counter_next = counter_reg;
        flags_next   = flags_reg;
        if (op.tick) begin
            if (!flags_reg[FL_LOCKED]) begin
                if (in_band) begin
                    if (counter_reg < limit) begin
                        counter_next = counter_reg + cnt_t'(1);
                    end else if (flags_reg[FL_RELEASED]) begin
                        flags_next[FL_PRESS_EV] = 1'b1;
                        flags_next[FL_PRESSED]  = 1'b1;
                        flags_next[FL_RELEASED] = 1'b0;
                    end
                end else begin
                    if (counter_reg != '0) begin
                        counter_next = counter_reg - cnt_t'(1);
                    end else if (flags_reg[FL_PRESSED]) begin
                        flags_next[FL_REL_EV]   = 1'b1;
                        flags_next[FL_RELEASED] = 1'b1;
                        flags_next[FL_PRESSED]  = 1'b0;
                    end
                end
            end
        end else if (op.clear && key_sel) begin
            flags_next = flags_reg & ~op.mask;
        end else if (op.set && key_sel) begin
            flags_next = flags_reg | op.mask;
        end
    end

    // State commits when the item moves into the result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            counter_reg <= '0;
            flags_reg   <= FLAGS_RESET;
        end else if (advance) begin
            counter_reg <= counter_next;
            flags_reg   <= flags_next;
        end
    end

`ifndef NO_ASSERTIONS
    // A locked key keeps its counter through a tick
    a_locked_frozen: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && op.tick && flags_reg[FL_LOCKED]) |=> $stable(counter_reg))
        else $error("locked key counter moved");

    // The counter moves by at most one step per transaction
    a_counter_step: assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> ((counter_reg == $past(counter_reg))
                     || (counter_reg == cnt_t'($past(counter_reg) + cnt_t'(1)))
                     || (counter_reg == cnt_t'($past(counter_reg) - cnt_t'(1)))))
        else $error("debounce counter jumped");

    // A tick outside the band never raises a press event
    a_no_press_out_of_band: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && op.tick && !in_band && !flags_reg[FL_PRESS_EV])
        |=> !flags_reg[FL_PRESS_EV])
        else $error("press event without band");
`endif

endmodule

// ===== rtl/ladder_keypad_debouncer.sv =====
// Top level of the five-key resistor ladder keypad debouncer.
// Depends on lkd_pkg, lkd_band_sorter and lkd_key_cell.
//
//  Channel   Direction  Handshake          Payload
//  s_        in         s_tvalid/s_tready  tuser: req_type; tdata: sample, key, mask
//  m_        out        m_tvalid/m_tready  tdata: flags of all five keys
//  cfg_      in         cfg_we only        cfg_addr register index, cfg_wdata value
//
// One transaction is taken per cycle while the result register is not stalled.
// Work is one pass of compares and counter updates between the item register
// and the result register; key state commits as the result register loads.
// A stalled result holds the item register, and s_tready drops while both
// registers are full and the result is not taken.
// Reset is synchronous; it empties both registers and restores keys and registers.

module ladder_keypad_debouncer (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    // Input channel
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // tdata: adc_sample, key_index, flag_mask, then zero padding
    input  logic [lkd_pkg::S_TDATA_BITS-1:0]     s_tdata,
    // tuser: req_type
    input  logic [lkd_pkg::REQ_BITS-1:0]         s_tuser,
    // Result channel
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // tdata: right, up, down, left, select flags, then zero padding
    output logic [lkd_pkg::M_TDATA_BITS-1:0]     m_tdata,
    // Configuration write port
    input  logic                                 cfg_we,
    input  logic [lkd_pkg::CFG_ADDR_BITS-1:0]    cfg_addr,
    input  logic [lkd_pkg::CFG_DATA_BITS-1:0]    cfg_wdata
);
    import lkd_pkg::*;

    // Configuration registers
    bounds_t bounds_reg;
    cnt_t    limit_reg;

    // Item register
    logic                  in_valid_reg;
    logic [REQ_BITS-1:0]   req_reg;
    sample_t               sample_reg;
    key_idx_t              idx_reg;
    flags_t                mask_reg;

    // Result register
    logic                      out_valid_reg;
    logic [M_TDATA_BITS-1:0]   out_data_reg;
    logic [M_TDATA_BITS-1:0]   out_data_next;

    logic                  advance;
    logic                  s_accept;
    key_op_t               op;
    logic [NUM_KEYS-1:0]   in_band;
    flags_t                key_flags_next [NUM_KEYS];

    // Flow control: the item moves on when the result register is free
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign s_accept = s_tvalid && s_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // Configuration writes; indexes beyond the list are ignored
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bounds_reg.right_upper       <= RST_RIGHT_UPPER;
            bounds_reg.up_lower          <= RST_UP_LOWER;
            bounds_reg.up_down_split     <= RST_UP_DOWN_SPLIT;
            bounds_reg.down_left_split   <= RST_DOWN_LEFT_SPLIT;
            bounds_reg.left_select_split <= RST_LEFT_SELECT_SPLIT;
            bounds_reg.select_upper      <= RST_SELECT_UPPER;
            limit_reg                    <= RST_DEBOUNCE_LIMIT;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                CFG_RIGHT_UPPER:       bounds_reg.right_upper       <= cfg_wdata;
                CFG_UP_LOWER:          bounds_reg.up_lower          <= cfg_wdata;
                CFG_UP_DOWN_SPLIT:     bounds_reg.up_down_split     <= cfg_wdata;
                CFG_DOWN_LEFT_SPLIT:   bounds_reg.down_left_split   <= cfg_wdata;
                CFG_LEFT_SELECT_SPLIT: bounds_reg.left_select_split <= cfg_wdata;
                CFG_SELECT_UPPER:      bounds_reg.select_upper      <= cfg_wdata;
                CFG_DEBOUNCE_LIMIT:    limit_reg <= cfg_wdata[CNT_BITS-1:0];
                default: begin
                end
            endcase
        end
    end

    // Item register: valid flag under reset, payload loaded on accept
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_accept) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            req_reg    <= s_tuser;
            sample_reg <= s_tdata[SAMPLE_BITS-1:0];
            idx_reg    <= s_tdata[SAMPLE_BITS +: KEY_IDX_BITS];
            mask_reg   <= s_tdata[SAMPLE_BITS + KEY_IDX_BITS +: FLAG_BITS];
        end
    end

    // Decode the request kind; the unused code changes nothing
    always_comb begin
        op      = '0;
        op.mask = mask_reg;
        unique case (req_reg)
            REQ_TICK:  op.tick  = 1'b1;
            REQ_CLEAR: op.clear = 1'b1;
            REQ_SET:   op.set   = 1'b1;
            default: begin
            end
        endcase
    end

    lkd_band_sorter u_band_sorter (
        .sample  (sample_reg),
        .bounds  (bounds_reg),
        .in_band (in_band)
    );

    // One cell per key, all judged from the same sample
    for (genvar k = 0; k < NUM_KEYS; k++) begin : g_key
        lkd_key_cell u_key_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .advance    (advance),
            .op         (op),
            .key_sel    (idx_reg == key_idx_t'(k)),
            .in_band    (in_band[k]),
            .limit      (limit_reg),
            .flags_next (key_flags_next[k])
        );
    end

    // Pack every key's updated flags, right key in the lowest bits
    always_comb begin
        out_data_next = '0;
        for (int k = 0; k < NUM_KEYS; k++) begin
            out_data_next[k*FLAG_BITS +: FLAG_BITS] = key_flags_next[k];
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_data_reg <= out_data_next;
        end
    end

`ifndef NO_ASSERTIONS
    // An empty item register always takes a new transaction
    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !in_valid_reg |-> s_tready)
        else $error("input refused while item register empty");

    // Both registers full with a stalled result blocks the input
    a_stall_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && out_valid_reg && !m_tready) |-> !s_tready)
        else $error("input taken while pipeline stalled");

    // Every item that moves on yields a result in the next cycle
    a_advance_gives_result: assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> m_tvalid)
        else $error("item advanced without a result");

    // Padding bits of the result stay zero
    a_result_padding: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ((m_tdata >> M_FIELD_BITS) == '0))
        else $error("result padding not zero");
`endif

endmodule
